// ===== rtl/arf_pkg.sv =====
// ----------------------------------------------------------------------------
// arf_pkg
// Shared types and codes for the aspect ratio fit scaler.
// ----------------------------------------------------------------------------
package arf_pkg;

    // Fit mode codes; the unused code behaves like FIT_IGNORE.
    typedef enum logic [1:0] {
        FIT_IGNORE = 2'd0,
        FIT_KEEP   = 2'd1,
        FIT_EXPAND = 2'd2
    } t_fit_mode;

    // Divide lanes: candidate width and alternate height.
    localparam int LANES  = 2;
    localparam int LANE_C = 0;
    localparam int LANE_A = 1;

    // Control that rides along with an item through the divider.
    typedef struct packed {
        logic bypass;   // return the target box unchanged
        logic expand;   // cover the box instead of fitting inside it
    } t_flags;

endpackage

// ===== rtl/aspect_ratio_fit_scaler.sv =====
// ----------------------------------------------------------------------------
// aspect_ratio_fit_scaler
// Fits a source size into a target box, ignoring, keeping or covering ratio.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one request per beat: source size,
//   target box and fit mode. Output channel o_valid/i_ready carries one
//   result per request, in order: width, height and a saturation flag.
//   The pipeline has one multiply stage, DIM_BITS divider stages at one
//   quotient bit each and one select stage. Throughput is one request per
//   cycle unless the output stalls; both quotients (width from target
//   height, height from target width) are computed side by side and the
//   select stage picks one, so no item waits on another.
//   Every stage holds its own valid bit. When the receiver stalls, beats
//   pile up behind the output register and bubbles are squeezed out;
//   o_ready drops only once every stage is full.
//   Reset clears all valid bits; nothing is in flight afterward.
// ----------------------------------------------------------------------------
module aspect_ratio_fit_scaler #(
    parameter int DIM_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [DIM_BITS-1:0] i_source_width,
    input  logic [DIM_BITS-1:0] i_source_height,
    input  logic [DIM_BITS-1:0] i_target_width,
    input  logic [DIM_BITS-1:0] i_target_height,
    input  logic [1:0]          i_fit_mode,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [DIM_BITS-1:0] o_result_width,
    output logic [DIM_BITS-1:0] o_result_height,
    output logic                o_saturated
);
    import arf_pkg::*;

    localparam logic [DIM_BITS-1:0] DIM_MAX = {DIM_BITS{1'b1}};
    localparam int                  SIDE_W  = 2 * DIM_BITS;

    // multiply stage
    logic                  r_a_valid;
    logic [2*DIM_BITS-1:0] r_a_prod_c;
    logic [2*DIM_BITS-1:0] r_a_prod_a;
    logic [DIM_BITS-1:0]   r_a_sw;
    logic [DIM_BITS-1:0]   r_a_sh;
    logic [DIM_BITS-1:0]   r_a_tw;
    logic [DIM_BITS-1:0]   r_a_th;
    t_flags                r_a_flags;

    logic [2*DIM_BITS-1:0] n_prod_c;
    logic [2*DIM_BITS-1:0] n_prod_a;
    t_flags                n_flags;
    logic                  a_rdy;

    // divider hookup
    logic                  div_rdy;
    logic                  div_valid;
    logic [DIM_BITS-1:0]   div_hi   [LANES];
    logic [DIM_BITS-1:0]   div_lo   [LANES];
    logic [DIM_BITS-1:0]   div_den  [LANES];
    logic [DIM_BITS-1:0]   div_quot [LANES];
    logic [LANES-1:0]      div_ovf;
    t_flags                div_flags;
    logic [SIDE_W-1:0]     div_side;

    // select stage
    logic                  r_o_valid;
    logic [DIM_BITS-1:0]   r_o_w;
    logic [DIM_BITS-1:0]   r_o_h;
    logic                  r_o_sat;
    logic [DIM_BITS-1:0]   n_o_w;
    logic [DIM_BITS-1:0]   n_o_h;
    logic                  n_o_sat;
    logic                  c_rdy;

    logic [DIM_BITS-1:0]   c_tw;
    logic [DIM_BITS-1:0]   c_th;
    logic                  c_keep_h;

    // candidate width numerator th*sw, alternate height numerator tw*sh
    always_comb begin
        n_prod_c       = SIDE_W'(i_target_height) * SIDE_W'(i_source_width);
        n_prod_a       = SIDE_W'(i_target_width)  * SIDE_W'(i_source_height);
        n_flags.expand = (i_fit_mode == FIT_EXPAND);
        n_flags.bypass = !((i_fit_mode == FIT_KEEP) || (i_fit_mode == FIT_EXPAND))
                         || (i_source_width == '0) || (i_source_height == '0);
    end

    assign a_rdy   = !r_a_valid || div_rdy;
    assign o_ready = a_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_rdy) begin
            r_a_valid <= i_valid;
        end
        if (a_rdy && i_valid) begin
            r_a_prod_c <= n_prod_c;
            r_a_prod_a <= n_prod_a;
            r_a_sw     <= i_source_width;
            r_a_sh     <= i_source_height;
            r_a_tw     <= i_target_width;
            r_a_th     <= i_target_height;
            r_a_flags  <= n_flags;
        end
    end

    always_comb begin
        div_hi[LANE_C]  = r_a_prod_c[2*DIM_BITS-1:DIM_BITS];
        div_lo[LANE_C]  = r_a_prod_c[DIM_BITS-1:0];
        div_den[LANE_C] = r_a_sh;
        div_hi[LANE_A]  = r_a_prod_a[2*DIM_BITS-1:DIM_BITS];
        div_lo[LANE_A]  = r_a_prod_a[DIM_BITS-1:0];
        div_den[LANE_A] = r_a_sw;
    end

    arf_div_pipe #(
        .DIM_BITS (DIM_BITS),
        .SIDE_W   (SIDE_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_a_valid),
        .o_ready  (div_rdy),
        .i_num_hi (div_hi),
        .i_num_lo (div_lo),
        .i_den    (div_den),
        .i_flags  (r_a_flags),
        .i_side   ({r_a_tw, r_a_th}),
        .o_valid  (div_valid),
        .i_ready  (c_rdy),
        .o_quot   (div_quot),
        .o_ovf    (div_ovf),
        .o_flags  (div_flags),
        .o_side   (div_side)
    );

    assign c_tw = div_side[SIDE_W-1:DIM_BITS];
    assign c_th = div_side[DIM_BITS-1:0];

    // an overflowed candidate is above any target width
    always_comb begin
        if (div_flags.expand) begin
            c_keep_h = div_ovf[LANE_C] || (div_quot[LANE_C] >= c_tw);
        end else begin
            c_keep_h = !div_ovf[LANE_C] && (div_quot[LANE_C] <= c_tw);
        end

        if (div_flags.bypass) begin
            n_o_w   = c_tw;
            n_o_h   = c_th;
            n_o_sat = 1'b0;
        end else if (c_keep_h) begin
            n_o_w   = div_ovf[LANE_C] ? DIM_MAX : div_quot[LANE_C];
            n_o_h   = c_th;
            n_o_sat = div_ovf[LANE_C];
        end else begin
            n_o_w   = c_tw;
            n_o_h   = div_ovf[LANE_A] ? DIM_MAX : div_quot[LANE_A];
            n_o_sat = div_ovf[LANE_A];
        end
    end

    assign c_rdy = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (c_rdy) begin
            r_o_valid <= div_valid;
        end
        if (c_rdy && div_valid) begin
            r_o_w   <= n_o_w;
            r_o_h   <= n_o_h;
            r_o_sat <= n_o_sat;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_result_width  = r_o_w;
    assign o_result_height = r_o_h;
    assign o_saturated     = r_o_sat;

`ifndef SYNTHESIS
    // a saturated result carries the maximum in one of its sides
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_o_sat |-> (r_o_w == DIM_MAX || r_o_h == DIM_MAX))
        else $error("saturation flag without a saturated side");

    // input backpressure only when the whole pipe is full and stalled
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready && r_a_valid))
        else $error("input stalled while the pipeline has room");

    // nothing leaves the block right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid directly after reset");
`endif

endmodule

// ===== rtl/arf_div_pipe.sv =====
// ----------------------------------------------------------------------------
// arf_div_pipe
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Each lane divides {num_hi, num_lo} by den. When num_hi >= den the quotient
// does not fit in DIM_BITS and the lane's overflow flag is set; the quotient
// bits are then meaningless.
// ----------------------------------------------------------------------------
module arf_div_pipe #(
    parameter int DIM_BITS = 16,
    parameter int SIDE_W   = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [DIM_BITS-1:0]  i_num_hi [arf_pkg::LANES],
    input  logic [DIM_BITS-1:0]  i_num_lo [arf_pkg::LANES],
    input  logic [DIM_BITS-1:0]  i_den    [arf_pkg::LANES],
    input  arf_pkg::t_flags      i_flags,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [DIM_BITS-1:0]  o_quot   [arf_pkg::LANES],
    output logic [arf_pkg::LANES-1:0] o_ovf,
    output arf_pkg::t_flags      o_flags,
    output logic [SIDE_W-1:0]    o_side
);
    import arf_pkg::*;

    localparam int STAGES = DIM_BITS;

    logic                r_v     [STAGES];
    logic [DIM_BITS-1:0] r_rem   [LANES][STAGES];
    logic [DIM_BITS-1:0] r_lo    [LANES][STAGES];
    logic [DIM_BITS-1:0] r_den   [LANES][STAGES];
    logic [LANES-1:0]    r_ovf   [STAGES];
    t_flags              r_flags [STAGES];
    logic [SIDE_W-1:0]   r_side  [STAGES];

    logic                up_v     [STAGES];
    logic [DIM_BITS-1:0] up_rem   [LANES][STAGES];
    logic [DIM_BITS-1:0] up_lo    [LANES][STAGES];
    logic [DIM_BITS-1:0] up_den   [LANES][STAGES];
    logic [LANES-1:0]    up_ovf   [STAGES];
    t_flags              up_flags [STAGES];
    logic [SIDE_W-1:0]   up_side  [STAGES];

    logic [DIM_BITS-1:0] n_rem [LANES][STAGES];
    logic [DIM_BITS-1:0] n_lo  [LANES][STAGES];
    logic                stg_rdy [STAGES];

    // stage inputs
    always_comb begin
        for (int j = 0; j < STAGES; j++) begin
            if (j == 0) begin
                up_v[j]     = i_valid;
                up_flags[j] = i_flags;
                up_side[j]  = i_side;
                for (int l = 0; l < LANES; l++) begin
                    up_rem[l][j]   = i_num_hi[l];
                    up_lo[l][j]    = i_num_lo[l];
                    up_den[l][j]   = i_den[l];
                    up_ovf[j][l]   = (i_num_hi[l] >= i_den[l]);
                end
            end else begin
                up_v[j]     = r_v[j-1];
                up_flags[j] = r_flags[j-1];
                up_side[j]  = r_side[j-1];
                up_ovf[j]   = r_ovf[j-1];
                for (int l = 0; l < LANES; l++) begin
                    up_rem[l][j] = r_rem[l][j-1];
                    up_lo[l][j]  = r_lo[l][j-1];
                    up_den[l][j] = r_den[l][j-1];
                end
            end
        end
    end

    // one restoring step per stage; quotient bits shift into the low word
    always_comb begin
        logic [DIM_BITS:0] t;
        logic              ge;
        t  = '0;
        ge = 1'b0;
        for (int j = 0; j < STAGES; j++) begin
            for (int l = 0; l < LANES; l++) begin
                t  = {up_rem[l][j], up_lo[l][j][DIM_BITS-1]};
                ge = (t >= {1'b0, up_den[l][j]});
                n_rem[l][j] = ge ? DIM_BITS'(t - {1'b0, up_den[l][j]})
                                 : t[DIM_BITS-1:0];
                n_lo[l][j]  = {up_lo[l][j][DIM_BITS-2:0], ge};
            end
        end
    end

    // a stage takes a beat when empty or when its own beat moves on
    always_comb begin
        for (int j = STAGES - 1; j >= 0; j--) begin
            if (j == STAGES - 1) begin
                stg_rdy[j] = !r_v[j] || i_ready;
            end else begin
                stg_rdy[j] = !r_v[j] || stg_rdy[j+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < STAGES; j++) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (stg_rdy[j]) begin
                r_v[j] <= up_v[j];
            end
            if (stg_rdy[j] && up_v[j]) begin
                r_flags[j] <= up_flags[j];
                r_side[j]  <= up_side[j];
                r_ovf[j]   <= up_ovf[j];
                for (int l = 0; l < LANES; l++) begin
                    r_rem[l][j] <= n_rem[l][j];
                    r_lo[l][j]  <= n_lo[l][j];
                    r_den[l][j] <= up_den[l][j];
                end
            end
        end
    end

    assign o_ready = stg_rdy[0];
    assign o_valid = r_v[STAGES-1];
    assign o_flags = r_flags[STAGES-1];
    assign o_side  = r_side[STAGES-1];
    assign o_ovf   = r_ovf[STAGES-1];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_quot[l] = r_lo[l][STAGES-1];
        end
    end

endmodule

// ===== tb/aspect_ratio_fit_scaler_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aspect_ratio_fit_scaler_tb
// Self-checking bench for the aspect ratio fit scaler. A scoreboard predicts
// each fitted size as requests are accepted and compares every result beat
// in order. Directed corner requests come first, then random requests with
// ratio-boundary targets, random idling on both channels, a stall-free run
// and one long output hold-off that backs the pipeline up.
// ----------------------------------------------------------------------------
module aspect_ratio_fit_scaler_tb;
    import arf_pkg::*;

    localparam int         DIM_BITS    = 16;
    localparam longint     DIM_MAX     = (64'd1 << DIM_BITS) - 1;
    localparam logic [1:0] FIT_UNUSED  = 2'd3;   // undefined code, acts as ignore
    localparam int         HOLD_CYCLES = 300;
    localparam int         IDLE_PCT    = 30;

    typedef logic [DIM_BITS-1:0] t_dim;

    typedef struct {
        t_dim width;
        t_dim height;
        logic sat;
    } t_fit_size;

    class fit_scoreboard;
        t_fit_size   pending_fits[$];
        int unsigned n_requests;
        int unsigned n_results;
        int unsigned n_errors;
        int unsigned n_saturated;
        int unsigned n_height_kept;
        int unsigned n_width_kept;
        int unsigned n_passthru;

        function t_fit_size predict_fit(t_dim sw, t_dim sh, t_dim tw, t_dim th,
                                        logic [1:0] mode);
            t_fit_size       fit;
            longint unsigned cand;
            longint unsigned alt;
            bit              keep_h;
            fit.width  = tw;
            fit.height = th;
            fit.sat    = 1'b0;
            if ((mode == FIT_KEEP || mode == FIT_EXPAND) && sw != 0 && sh != 0) begin
                cand   = (longint'(th) * longint'(sw)) / longint'(sh);
                keep_h = (mode == FIT_KEEP) ? (cand <= 64'(tw)) : (cand >= 64'(tw));
                if (keep_h) begin
                    n_height_kept++;
                    if (cand > DIM_MAX) begin
                        fit.sat   = 1'b1;
                        fit.width = t_dim'(DIM_MAX);
                    end else begin
                        fit.width = t_dim'(cand);
                    end
                end else begin
                    n_width_kept++;
                    alt = (longint'(tw) * longint'(sh)) / longint'(sw);
                    if (alt > DIM_MAX) begin
                        fit.sat    = 1'b1;
                        fit.height = t_dim'(DIM_MAX);
                    end else begin
                        fit.height = t_dim'(alt);
                    end
                end
            end else begin
                n_passthru++;
            end
            return fit;
        endfunction

        function void note_request(t_dim sw, t_dim sh, t_dim tw, t_dim th,
                                   logic [1:0] mode);
            t_fit_size fit;
            fit = predict_fit(sw, sh, tw, th, mode);
            if (fit.sat) n_saturated++;
            n_requests++;
            pending_fits.push_back(fit);
        endfunction

        function void check_result(t_dim rw, t_dim rh, logic sat);
            t_fit_size fit;
            n_results++;
            if (pending_fits.size() == 0) begin
                $error("result beat with nothing pending: width %0d height %0d sat %0b",
                       rw, rh, sat);
                n_errors++;
                return;
            end
            fit = pending_fits.pop_front();
            if (rw !== fit.width) begin
                $error("result_width: expected %0d, got %0d", fit.width, rw);
                n_errors++;
            end
            if (rh !== fit.height) begin
                $error("result_height: expected %0d, got %0d", fit.height, rh);
                n_errors++;
            end
            if (sat !== fit.sat) begin
                $error("saturated: expected %0b, got %0b", fit.sat, sat);
                n_errors++;
            end
        endfunction
    endclass

    logic i_clk           = 1'b0;
    logic i_rst_n         = 1'b0;
    logic i_valid         = 1'b0;
    logic i_ready         = 1'b0;
    t_dim i_source_width  = '0;
    t_dim i_source_height = '0;
    t_dim i_target_width  = '0;
    t_dim i_target_height = '0;
    logic [1:0] i_fit_mode = FIT_IGNORE;
    logic o_ready;
    logic o_valid;
    t_dim o_result_width;
    t_dim o_result_height;
    logic o_saturated;

    fit_scoreboard sb = new;

    bit tx_gaps   = 1'b1;
    bit rx_steady = 1'b0;
    bit hold_req  = 1'b0;
    bit in_reset  = 1'b1;

    aspect_ratio_fit_scaler #(
        .DIM_BITS (DIM_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_source_width  (i_source_width),
        .i_source_height (i_source_height),
        .i_target_width  (i_target_width),
        .i_target_height (i_target_height),
        .i_fit_mode      (i_fit_mode),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_result_width  (o_result_width),
        .o_result_height (o_result_height),
        .o_saturated     (o_saturated)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // Result side: check every accepted beat, then pick next cycle's ready.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (!in_reset && o_valid && i_ready)
                sb.check_result(o_result_width, o_result_height, o_saturated);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (rx_steady) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Offer one request, optionally after random idle cycles; returns in the
    // step of the accepting edge.
    task automatic send_fit(t_dim sw, t_dim sh, t_dim tw, t_dim th, logic [1:0] mode);
        int gap;
        gap = 0;
        if (tx_gaps)
            while ($urandom_range(99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_source_width  <= sw;
        i_source_height <= sh;
        i_target_width  <= tw;
        i_target_height <= th;
        i_fit_mode      <= mode;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(sw, sh, tw, th, mode);
    endtask

    function automatic t_dim rand_dim();
        t_dim d;
        case ($urandom_range(9))
            0:       d = t_dim'($urandom_range(16));
            1:       d = t_dim'(DIM_MAX - $urandom_range(3));
            2:       d = t_dim'(1) << $urandom_range(DIM_BITS - 1);
            3:       d = t_dim'($urandom_range(4095));
            default: d = t_dim'($urandom);
        endcase
        return d;
    endfunction

    task automatic send_random_fit();
        t_dim            sw;
        t_dim            sh;
        t_dim            tw;
        t_dim            th;
        logic [1:0]      mode;
        longint unsigned cand;
        int              pick;
        sw   = rand_dim();
        sh   = rand_dim();
        tw   = rand_dim();
        th   = rand_dim();
        pick = $urandom_range(99);
        if (pick < 45)      mode = FIT_KEEP;
        else if (pick < 90) mode = FIT_EXPAND;
        else if (pick < 95) mode = FIT_IGNORE;
        else                mode = FIT_UNUSED;
        // Put the target width at or one off the candidate to hit the keep decision edge.
        if (sh != 0 && $urandom_range(3) == 0) begin
            cand = (longint'(th) * longint'(sw)) / longint'(sh);
            if (cand <= DIM_MAX) begin
                cand = cand + 64'($urandom_range(2));
                cand = (cand == 0) ? 0 : cand - 1;
                tw   = (cand > DIM_MAX) ? t_dim'(DIM_MAX) : t_dim'(cand);
            end
        end
        send_fit(sw, sh, tw, th, mode);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        in_reset  = 1'b0;

        // Directed corners: extremes, every mode, zero source sides, ties.
        send_fit(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, FIT_KEEP);
        send_fit(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, FIT_EXPAND);
        send_fit(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, FIT_IGNORE);
        send_fit(16'h1234, 16'h0021, 16'hABCD, 16'h5678, FIT_UNUSED);
        send_fit(16'd0,    16'd0,    16'd0,    16'd0,    FIT_KEEP);
        send_fit(16'd0,    16'd300,  16'd640,  16'd480,  FIT_KEEP);
        send_fit(16'd400,  16'd0,    16'd640,  16'd480,  FIT_EXPAND);
        send_fit(16'hFFFF, 16'd1,    16'hFFFF, 16'hFFFF, FIT_KEEP);
        send_fit(16'hFFFF, 16'd1,    16'hFFFF, 16'hFFFF, FIT_EXPAND);
        send_fit(16'd1,    16'hFFFF, 16'hFFFF, 16'd1,    FIT_KEEP);
        send_fit(16'd1,    16'hFFFF, 16'hFFFF, 16'd1,    FIT_EXPAND);
        send_fit(16'd4,    16'd3,    16'd400,  16'd300,  FIT_KEEP);
        send_fit(16'd4,    16'd3,    16'd400,  16'd300,  FIT_EXPAND);
        send_fit(16'd16,   16'd9,    16'd1920, 16'd1200, FIT_KEEP);
        send_fit(16'd16,   16'd9,    16'd1920, 16'd1200, FIT_EXPAND);
        send_fit(16'd3,    16'd4,    16'd0,    16'd500,  FIT_KEEP);
        send_fit(16'd3,    16'd4,    16'd500,  16'd0,    FIT_EXPAND);
        send_fit(16'd2,    16'd1,    16'h8000, 16'h8000, FIT_EXPAND);
        send_fit(16'd1,    16'd2,    16'h8000, 16'h8000, FIT_KEEP);
        send_fit(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, FIT_EXPAND);

        repeat (600) send_random_fit();

        // No idling on either side.
        tx_gaps   = 1'b0;
        rx_steady = 1'b1;
        repeat (400) send_random_fit();

        // Long output hold-off while requests keep coming, so the input stalls.
        rx_steady = 1'b0;
        hold_req  = 1'b1;
        repeat (200) send_random_fit();

        tx_gaps = 1'b1;
        repeat (730) send_random_fit();
        i_valid <= 1'b0;

        rx_steady = 1'b1;
        while (sb.pending_fits.size() != 0) @(posedge i_clk);
        repeat (DIM_BITS + 24) @(posedge i_clk);

        $display("summary: %0d requests, %0d results; height kept %0d, width kept %0d",
                 sb.n_requests, sb.n_results, sb.n_height_kept, sb.n_width_kept);
        $display("summary: %0d passed through, %0d saturated, %0d mismatches",
                 sb.n_passthru, sb.n_saturated, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
